// ===== src/bzq_pkg.sv =====
// Shared constants and types for the battery zone start/stop qualifier.
// No dependencies; used by every module of the block by scoped name.
`default_nettype none

package bzq_pkg;

    // Default voltage width in bits
    localparam int VOLT_BITS_DEF = 16;

    // Configuration port
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_MV        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_MV        = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CONFIRM_TICKS = 2'd2;

    // Register reset values
    localparam int          MIN_MV_RST        = 11500;
    localparam int          MAX_MV_RST        = 13800;
    localparam logic [7:0]  CONFIRM_TICKS_RST = 8'd10;

    // Field widths
    localparam int AGE_W  = 8;
    localparam int LOST_W = 16;

    // Zone codes
    localparam logic [1:0] ZONE_UNKNOWN = 2'd0;
    localparam logic [1:0] ZONE_LOW     = 2'd1;
    localparam logic [1:0] ZONE_NORMAL  = 2'd2;
    localparam logic [1:0] ZONE_HIGH    = 2'd3;

    // Action codes
    localparam logic [1:0] ACT_NONE  = 2'd0;
    localparam logic [1:0] ACT_START = 2'd1;
    localparam logic [1:0] ACT_STOP  = 2'd2;

    // One result word
    typedef struct packed {
        logic [1:0]        action;
        logic [1:0]        settled_zone;
        logic              data_ok;
        logic [LOST_W-1:0] lost_seconds;
    } t_res;

endpackage

`default_nettype wire

// ===== src/battery_zone_start_stop_qualifier.sv =====
// Battery zone start/stop qualifier, top level.
// Input channel: i_in_valid / o_in_stall with i_voltage_mv, i_voltage_ok,
// i_auto_on; a word is taken at a rising edge with valid high and stall low.
// Output channel: o_out_valid / i_out_stall with o_action, o_settled_zone,
// o_data_ok, o_lost_seconds; exactly one result word per input word.
// Configuration: i_cfg_we, i_cfg_idx, i_cfg_data write min_mv (0), max_mv (1)
// and confirm_ticks (2); other indexes are ignored. A threshold write clears
// all zone and lost-time tracking. Write only while the block is idle.
// Word path: the input register loads at the accepting edge and the result
// register loads from it once it is empty or being drained; o_out_valid rises
// with that load. Throughput: one word per cycle while i_out_stall is low, as
// the tracking registers update in the same cycle as the result register.
// Reset (i_rst_n low, synchronous): registers go to 11500, 13800 and 10,
// tracking is cleared, both pipeline registers are emptied.
// While i_out_stall is high the result word holds; the input register still
// takes one more word, then o_in_stall rises until the result is taken.
// Depends on bzq_pkg, bzq_cfg and bzq_track.
`default_nettype none

module battery_zone_start_stop_qualifier #(
    parameter int VOLT_BITS = bzq_pkg::VOLT_BITS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,

    input  wire logic                             i_in_valid,
    output logic                                  o_in_stall,
    input  wire logic [VOLT_BITS-1:0]             i_voltage_mv,
    input  wire logic                             i_voltage_ok,
    input  wire logic                             i_auto_on,

    output logic                                  o_out_valid,
    input  wire logic                             i_out_stall,
    output logic      [1:0]                       o_action,
    output logic      [1:0]                       o_settled_zone,
    output logic                                  o_data_ok,
    output logic      [bzq_pkg::LOST_W-1:0]       o_lost_seconds,

    input  wire logic                             i_cfg_we,
    input  wire logic [bzq_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [bzq_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    logic                      r_s1_valid;
    logic [VOLT_BITS-1:0]      r_voltage_mv;
    logic                      r_voltage_ok;
    logic                      r_auto_on;
    logic                      r_out_valid;

    logic                      advance;
    logic                      go;
    logic                      in_take;

    logic [VOLT_BITS-1:0]      min_mv;
    logic [VOLT_BITS-1:0]      max_mv;
    logic [bzq_pkg::AGE_W-1:0] confirm_ticks;
    logic                      clear;
    bzq_pkg::t_res             res;

    // result register can be loaded when empty or being drained
    assign advance    = !r_out_valid || !i_out_stall;
    assign go         = r_s1_valid && advance;
    assign o_in_stall = r_s1_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_s1_valid <= 1'b1;
            end else if (go) begin
                r_s1_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_voltage_mv <= i_voltage_mv;
            r_voltage_ok <= i_voltage_ok;
            r_auto_on    <= i_auto_on;
        end
    end

    bzq_cfg #(
        .VOLT_BITS (VOLT_BITS)
    ) u_cfg (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .o_min_mv        (min_mv),
        .o_max_mv        (max_mv),
        .o_confirm_ticks (confirm_ticks),
        .o_clear         (clear)
    );

    bzq_track #(
        .VOLT_BITS (VOLT_BITS)
    ) u_track (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_go            (go),
        .i_voltage_mv    (r_voltage_mv),
        .i_voltage_ok    (r_voltage_ok),
        .i_auto_on       (r_auto_on),
        .i_min_mv        (min_mv),
        .i_max_mv        (max_mv),
        .i_confirm_ticks (confirm_ticks),
        .i_clear         (clear),
        .o_res           (res)
    );

    assign o_out_valid    = r_out_valid;
    assign o_action       = res.action;
    assign o_settled_zone = res.settled_zone;
    assign o_data_ok      = res.data_ok;
    assign o_lost_seconds = res.lost_seconds;

endmodule

`default_nettype wire

// ===== src/bzq_cfg.sv =====
// Configuration registers: thresholds and confirm count.
// Depends on bzq_pkg; raises a clear strobe on any threshold write.
`default_nettype none

module bzq_cfg #(
    parameter int VOLT_BITS = bzq_pkg::VOLT_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [bzq_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [bzq_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output logic      [VOLT_BITS-1:0]              o_min_mv,
    output logic      [VOLT_BITS-1:0]              o_max_mv,
    output logic      [bzq_pkg::AGE_W-1:0]         o_confirm_ticks,
    output logic                                   o_clear
);

    logic [VOLT_BITS-1:0]      r_min_mv;
    logic [VOLT_BITS-1:0]      r_max_mv;
    logic [bzq_pkg::AGE_W-1:0] r_confirm_ticks;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_mv        <= VOLT_BITS'(bzq_pkg::MIN_MV_RST);
            r_max_mv        <= VOLT_BITS'(bzq_pkg::MAX_MV_RST);
            r_confirm_ticks <= bzq_pkg::CONFIRM_TICKS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                bzq_pkg::CFG_MIN_MV:        r_min_mv <= VOLT_BITS'(i_cfg_data);
                bzq_pkg::CFG_MAX_MV:        r_max_mv <= VOLT_BITS'(i_cfg_data);
                bzq_pkg::CFG_CONFIRM_TICKS: r_confirm_ticks <= i_cfg_data[bzq_pkg::AGE_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_min_mv        = r_min_mv;
    assign o_max_mv        = r_max_mv;
    assign o_confirm_ticks = r_confirm_ticks;
    assign o_clear         = i_cfg_we &&
                             (i_cfg_idx == bzq_pkg::CFG_MIN_MV ||
                              i_cfg_idx == bzq_pkg::CFG_MAX_MV);

endmodule

`default_nettype wire

// ===== src/bzq_track.sv =====
// Zone classification, debounce tracking, lost-data counter and result register.
// Depends on bzq_pkg; fed from the input register of the top level.
`default_nettype none

module bzq_track #(
    parameter int VOLT_BITS = bzq_pkg::VOLT_BITS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_go,
    input  wire logic [VOLT_BITS-1:0]        i_voltage_mv,
    input  wire logic                        i_voltage_ok,
    input  wire logic                        i_auto_on,
    input  wire logic [VOLT_BITS-1:0]        i_min_mv,
    input  wire logic [VOLT_BITS-1:0]        i_max_mv,
    input  wire logic [bzq_pkg::AGE_W-1:0]   i_confirm_ticks,
    input  wire logic                        i_clear,
    output bzq_pkg::t_res                    o_res
);

    logic [1:0]                 r_confirmed_zone, n_confirmed_zone;
    logic [1:0]                 r_candidate_zone, n_candidate_zone;
    logic [bzq_pkg::AGE_W-1:0]  r_candidate_age,  n_candidate_age;
    logic                       r_lost_active,    n_lost_active;
    logic [bzq_pkg::LOST_W-1:0] r_lost_ticks,     n_lost_ticks;
    bzq_pkg::t_res              r_res,            n_res;

    logic [1:0]                 cur_zone;
    logic [bzq_pkg::AGE_W-1:0]  age_inc;
    logic [bzq_pkg::LOST_W-1:0] lost_inc;
    logic [1:0]                 action;

    // Low test wins when the thresholds cross
    always_comb begin
        if (i_voltage_mv <= i_min_mv) begin
            cur_zone = bzq_pkg::ZONE_LOW;
        end else if (i_voltage_mv >= i_max_mv) begin
            cur_zone = bzq_pkg::ZONE_HIGH;
        end else begin
            cur_zone = bzq_pkg::ZONE_NORMAL;
        end
    end

    assign age_inc  = (r_candidate_age == '1) ? r_candidate_age
                                              : r_candidate_age + 1'b1;
    assign lost_inc = (r_lost_ticks == '1) ? r_lost_ticks : r_lost_ticks + 1'b1;

    always_comb begin
        n_confirmed_zone = r_confirmed_zone;
        n_candidate_zone = r_candidate_zone;
        n_candidate_age  = r_candidate_age;
        n_lost_active    = r_lost_active;
        n_lost_ticks     = r_lost_ticks;
        action           = bzq_pkg::ACT_NONE;

        if (!i_auto_on) begin
            // zone state holds, but lost time keeps counting
            if (r_lost_active) begin
                n_lost_ticks = lost_inc;
            end
        end else if (!i_voltage_ok) begin
            n_candidate_zone = bzq_pkg::ZONE_UNKNOWN;
            n_candidate_age  = '0;
            n_lost_active    = 1'b1;
            n_lost_ticks     = r_lost_active ? lost_inc : '0;
        end else begin
            n_lost_active = 1'b0;
            n_lost_ticks  = '0;
            if (cur_zone != r_candidate_zone) begin
                n_candidate_zone = cur_zone;
                n_candidate_age  = '0;
            end else begin
                n_candidate_age = age_inc;
                if (cur_zone != r_confirmed_zone && age_inc >= i_confirm_ticks) begin
                    n_confirmed_zone = cur_zone;
                    case (cur_zone)
                        bzq_pkg::ZONE_LOW:  action = bzq_pkg::ACT_START;
                        bzq_pkg::ZONE_HIGH: action = bzq_pkg::ACT_STOP;
                        default:            action = bzq_pkg::ACT_NONE;
                    endcase
                end
            end
        end

        n_res.action       = action;
        n_res.settled_zone = n_confirmed_zone;
        n_res.data_ok      = i_auto_on && i_voltage_ok;
        n_res.lost_seconds = n_lost_active ? n_lost_ticks : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_confirmed_zone <= bzq_pkg::ZONE_UNKNOWN;
            r_candidate_zone <= bzq_pkg::ZONE_UNKNOWN;
            r_candidate_age  <= '0;
            r_lost_active    <= 1'b0;
            r_lost_ticks     <= '0;
        end else if (i_go) begin
            r_confirmed_zone <= n_confirmed_zone;
            r_candidate_zone <= n_candidate_zone;
            r_candidate_age  <= n_candidate_age;
            r_lost_active    <= n_lost_active;
            r_lost_ticks     <= n_lost_ticks;
        end
    end

    // result word: payload only, valid lives in the top level
    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_res <= n_res;
        end
    end

    assign o_res = r_res;

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// Self-checking testbench for battery_zone_start_stop_qualifier.
// Sends directed and random sample words, predicts every result word in-line
// and compares it field by field. Depends on bzq_pkg and the block's RTL.
`timescale 1ns / 100ps

module tb;

    localparam int IDLE_LIMIT    = 1000;
    localparam int GAP_MAX       = 13;
    localparam int SETTLE_CYCLES = 6;
    localparam int PHASE_WORDS   = 50;
    localparam int RANDOM_PHASES = 3;
    localparam logic [bzq_pkg::CFG_IDX_W-1:0] CFG_IDX_UNUSED = 2'd3;

    logic                           i_clk        = 1'b0;
    logic                           i_rst_n      = 1'b0;
    logic                           i_in_valid   = 1'b0;
    logic [15:0]                    i_voltage_mv = '0;
    logic                           i_voltage_ok = 1'b0;
    logic                           i_auto_on    = 1'b0;
    logic                           i_out_stall  = 1'b0;
    logic                           i_cfg_we     = 1'b0;
    logic [bzq_pkg::CFG_IDX_W-1:0]  i_cfg_idx    = '0;
    logic [bzq_pkg::CFG_DATA_W-1:0] i_cfg_data   = '0;

    logic                           o_in_stall;
    logic                           o_out_valid;
    logic [1:0]                     o_action;
    logic [1:0]                     o_settled_zone;
    logic                           o_data_ok;
    logic [bzq_pkg::LOST_W-1:0]     o_lost_seconds;

    battery_zone_start_stop_qualifier #(
        .VOLT_BITS(16)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_voltage_mv   (i_voltage_mv),
        .i_voltage_ok   (i_voltage_ok),
        .i_auto_on      (i_auto_on),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_action       (o_action),
        .o_settled_zone (o_settled_zone),
        .o_data_ok      (o_data_ok),
        .o_lost_seconds (o_lost_seconds),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Predictor copy of registers and tracking state
    logic [15:0] thr_lo;
    logic [15:0] thr_hi;
    logic [7:0]  confirm_need;
    logic [1:0]  zone_settled;
    logic [1:0]  zone_cand;
    logic [7:0]  cand_age;
    logic        lost_flag;
    logic [15:0] lost_count;

    bzq_pkg::t_res zone_results_due[$];
    int   n_errors    = 0;
    int   n_words_out = 0;
    bit   calm        = 1'b0;
    int   idle_cycles = 0;

    function automatic void clear_zone_tracking();
        zone_settled = bzq_pkg::ZONE_UNKNOWN;
        zone_cand    = bzq_pkg::ZONE_UNKNOWN;
        cand_age     = '0;
        lost_flag    = 1'b0;
        lost_count   = '0;
    endfunction

    function automatic void reset_predictor();
        thr_lo       = 16'(bzq_pkg::MIN_MV_RST);
        thr_hi       = 16'(bzq_pkg::MAX_MV_RST);
        confirm_need = bzq_pkg::CONFIRM_TICKS_RST;
        clear_zone_tracking();
    endfunction

    function automatic void apply_reg_write(input logic [bzq_pkg::CFG_IDX_W-1:0] idx,
                                            input logic [bzq_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            bzq_pkg::CFG_MIN_MV: begin
                thr_lo = data;
                clear_zone_tracking();
            end
            bzq_pkg::CFG_MAX_MV: begin
                thr_hi = data;
                clear_zone_tracking();
            end
            bzq_pkg::CFG_CONFIRM_TICKS: begin
                confirm_need = data[7:0];
            end
            default: begin
            end
        endcase
    endfunction

    // Low test comes first, so crossed thresholds resolve to low
    function automatic logic [1:0] zone_of(input logic [15:0] v);
        if (v <= thr_lo)
            return bzq_pkg::ZONE_LOW;
        if (v >= thr_hi)
            return bzq_pkg::ZONE_HIGH;
        return bzq_pkg::ZONE_NORMAL;
    endfunction

    function automatic bzq_pkg::t_res predict_zone_result(input logic [15:0] v,
                                                          input logic ok,
                                                          input logic au);
        bzq_pkg::t_res r;
        logic [1:0]    z;
        r.action = bzq_pkg::ACT_NONE;
        if (!au) begin
            if (lost_flag && lost_count != 16'hFFFF)
                lost_count++;
        end else if (!ok) begin
            zone_cand = bzq_pkg::ZONE_UNKNOWN;
            cand_age  = '0;
            if (!lost_flag) begin
                lost_flag  = 1'b1;
                lost_count = '0;
            end else if (lost_count != 16'hFFFF) begin
                lost_count++;
            end
        end else begin
            z          = zone_of(v);
            lost_flag  = 1'b0;
            lost_count = '0;
            if (z != zone_cand) begin
                zone_cand = z;
                cand_age  = '0;
            end else begin
                if (cand_age != 8'hFF)
                    cand_age++;
                if (z != zone_settled && cand_age >= confirm_need) begin
                    if (z == bzq_pkg::ZONE_LOW)
                        r.action = bzq_pkg::ACT_START;
                    else if (z == bzq_pkg::ZONE_HIGH)
                        r.action = bzq_pkg::ACT_STOP;
                    zone_settled = z;
                end
            end
        end
        r.settled_zone = zone_settled;
        r.data_ok      = au && ok;
        r.lost_seconds = lost_flag ? lost_count : '0;
        return r;
    endfunction

    function automatic logic [15:0] pick_voltage(input logic [1:0] zone);
        int lo_i;
        int hi_i;
        lo_i = int'(thr_lo);
        hi_i = int'(thr_hi);
        case (zone)
            bzq_pkg::ZONE_LOW:  return 16'($urandom_range(0, lo_i));
            bzq_pkg::ZONE_HIGH: return 16'($urandom_range(hi_i, 16'hFFFF));
            default: begin
                if (hi_i > lo_i + 1)
                    return 16'($urandom_range(lo_i + 1, hi_i - 1));
                return 16'($urandom_range(0, 16'hFFFF));
            end
        endcase
    endfunction

    task automatic report(input string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        n_errors++;
    endtask

    // All tasks below start and end just after a rising edge
    task automatic send_word(input logic [15:0] v, input logic ok, input logic au);
        int gap;
        gap = calm ? 0 : $urandom_range(0, GAP_MAX);
        repeat (gap) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_voltage_mv <= v;
        i_voltage_ok <= ok;
        i_auto_on    <= au;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        zone_results_due.push_back(predict_zone_result(v, ok, au));
    endtask

    task automatic send_run(input logic [15:0] v, input logic ok, input logic au,
                            input int n);
        repeat (n)
            send_word(v, ok, au);
    endtask

    task automatic drain_block();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (zone_results_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES)
            @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [bzq_pkg::CFG_IDX_W-1:0] idx,
                             input logic [bzq_pkg::CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        apply_reg_write(idx, data);
        @(posedge i_clk);
    endtask

    // Result side: check each accepted word, then hold stall for a drawn count
    initial begin : result_monitor
        int            hold;
        bzq_pkg::t_res want;
        hold = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                if (zone_results_due.size() == 0) begin
                    report($sformatf("result word %0d with nothing pending", n_words_out));
                end else begin
                    want = zone_results_due.pop_front();
                    if (o_action !== want.action)
                        report($sformatf("word %0d action: got %0d, want %0d",
                                         n_words_out, o_action, want.action));
                    if (o_settled_zone !== want.settled_zone)
                        report($sformatf("word %0d settled_zone: got %0d, want %0d",
                                         n_words_out, o_settled_zone, want.settled_zone));
                    if (o_data_ok !== want.data_ok)
                        report($sformatf("word %0d data_ok: got %0d, want %0d",
                                         n_words_out, o_data_ok, want.data_ok));
                    if (o_lost_seconds !== want.lost_seconds)
                        report($sformatf("word %0d lost_seconds: got %0d, want %0d",
                                         n_words_out, o_lost_seconds, want.lost_seconds));
                end
                n_words_out++;
                hold = calm ? 0 : $urandom_range(0, GAP_MAX);
            end
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                hold--;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Register defaults: default low and high thresholds at their boundaries, default confirm
    task automatic test_reset_values();
        send_run(16'd11500, 1'b1, 1'b1, 11);
        send_run(16'd13800, 1'b1, 1'b1, 2);
    endtask

    task automatic test_field_extremes();
        drain_block();
        write_reg(bzq_pkg::CFG_MIN_MV, 16'd0);
        write_reg(bzq_pkg::CFG_MAX_MV, 16'hFFFF);
        write_reg(bzq_pkg::CFG_CONFIRM_TICKS, 16'd2);
        send_run(16'd0, 1'b1, 1'b1, 3);
        send_run(16'hFFFF, 1'b1, 1'b1, 3);
        send_run(16'd1, 1'b1, 1'b1, 3);
        drain_block();
        write_reg(bzq_pkg::CFG_MIN_MV, 16'hFFFF);
        send_run(16'hFFFF, 1'b1, 1'b1, 3);
    endtask

    task automatic test_crossed_thresholds();
        drain_block();
        write_reg(bzq_pkg::CFG_MIN_MV, 16'd13000);
        write_reg(bzq_pkg::CFG_MAX_MV, 16'd12000);
        write_reg(bzq_pkg::CFG_CONFIRM_TICKS, 16'd1);
        send_run(16'd12500, 1'b1, 1'b1, 2);
        send_run(16'd13500, 1'b1, 1'b1, 2);
    endtask

    // Lost data in auto mode, then auto off with and without valid data
    task automatic test_lost_and_auto_off();
        drain_block();
        write_reg(bzq_pkg::CFG_MIN_MV, 16'd11500);
        write_reg(bzq_pkg::CFG_MAX_MV, 16'd13800);
        send_run(16'd12000, 1'b1, 1'b1, 2);
        send_run(16'd9000, 1'b0, 1'b1, 3);
        send_run(16'd9000, 1'b0, 1'b0, 1);
        send_run(16'd9000, 1'b1, 1'b0, 1);
        send_run(16'd12000, 1'b1, 1'b1, 2);
        send_run(16'd9000, 1'b1, 1'b0, 2);
    endtask

    // Unused index and confirm writes must leave tracking alone; confirm takes low byte
    task automatic test_register_writes();
        drain_block();
        write_reg(bzq_pkg::CFG_CONFIRM_TICKS, 16'hFF03);
        send_run(16'd11000, 1'b1, 1'b1, 2);
        drain_block();
        write_reg(CFG_IDX_UNUSED, 16'd0);
        write_reg(bzq_pkg::CFG_CONFIRM_TICKS, 16'h0002);
        send_run(16'd11000, 1'b1, 1'b1, 1);
    endtask

    // Zero confirm acts on the second word; threshold write clears the settled zone
    task automatic test_zero_confirm();
        drain_block();
        write_reg(bzq_pkg::CFG_CONFIRM_TICKS, 16'd0);
        send_run(16'd13900, 1'b1, 1'b1, 2);
        drain_block();
        write_reg(bzq_pkg::CFG_MAX_MV, 16'd13800);
        send_run(16'd13900, 1'b1, 1'b1, 2);
    endtask

    task automatic test_long_confirm();
        drain_block();
        write_reg(bzq_pkg::CFG_CONFIRM_TICKS, 16'd255);
        calm = 1'b1;
        send_run(16'd12000, 1'b1, 1'b1, 260);
        calm = 1'b0;
    endtask

    // Lost count keeps running with auto off, then valid data clears it
    task automatic test_lost_recovery();
        drain_block();
        calm = 1'b1;
        send_run(16'd5000, 1'b0, 1'b1, 6);
        send_run(16'd5000, 1'b0, 1'b0, 2);
        send_run(16'd12000, 1'b1, 1'b1, 1);
        calm = 1'b0;
    endtask

    task automatic configure_random_phase();
        int          sel;
        logic [15:0] lo_v;
        logic [15:0] hi_v;
        logic [15:0] conf_v;
        lo_v = 16'($urandom_range(0, 40000));
        hi_v = 16'(lo_v + $urandom_range(0, 25000));
        sel  = $urandom_range(0, 5);
        case (sel)
            0: begin
                lo_v = 16'd0;
                hi_v = 16'hFFFF;
            end
            1: lo_v = 16'hFFFF;
            2: hi_v = 16'd0;
            3: hi_v = lo_v;
            default: begin
            end
        endcase
        sel = $urandom_range(0, 7);
        if (sel == 0)
            conf_v = 16'd0;
        else if (sel == 1)
            conf_v = 16'($urandom_range(7, 12));
        else
            conf_v = 16'($urandom_range(1, 5));
        // Upper byte of a confirm write is junk
        conf_v[15:8] = 8'($urandom_range(0, 255));
        drain_block();
        write_reg(bzq_pkg::CFG_MIN_MV, lo_v);
        write_reg(bzq_pkg::CFG_MAX_MV, hi_v);
        write_reg(bzq_pkg::CFG_CONFIRM_TICKS, conf_v);
    endtask

    // Runs of one zone, some long enough to confirm, with noise words mixed in
    task automatic test_random_phases();
        int         sent;
        int         run_len;
        logic [1:0] zone;
        repeat (RANDOM_PHASES) begin
            configure_random_phase();
            sent = 0;
            while (sent < PHASE_WORDS) begin
                zone    = 2'($urandom_range(1, 3));
                run_len = $urandom_range(1, int'(confirm_need) + 3);
                calm    = ($urandom_range(0, 3) == 0);
                repeat (run_len) begin
                    case ($urandom_range(0, 11))
                        0: send_word(16'($urandom), 1'b0, 1'b1);
                        1: send_word(16'($urandom), 1'($urandom), 1'b0);
                        2: send_word(16'($urandom), 1'b1, 1'b1);
                        default: send_word(pick_voltage(zone), 1'b1, 1'b1);
                    endcase
                    sent++;
                end
            end
            calm = 1'b0;
        end
    endtask

    initial begin
        reset_predictor();
        repeat (11)
            @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_values();
        test_field_extremes();
        test_crossed_thresholds();
        test_lost_and_auto_off();
        test_register_writes();
        test_zero_confirm();
        test_long_confirm();
        test_lost_recovery();
        test_random_phases();
        drain_block();
        if (n_errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
